### rtl/cwp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cwp_pkg;

    // Angle divider: 16 quotient bits, two per stage.
    localparam int DivStepsPerStage = 2;
    localparam int DivStages        = 8;
    // Square root: 8 result bits, two per stage, in the first stages of the divider.
    localparam int SqrtStages       = 4;

    // Q16 angle constants.
    localparam logic signed [20:0] QPi    = 21'sd205887;
    localparam logic signed [20:0] QPiBy2 = 21'sd102944;
    localparam logic signed [20:0] QTwoPi = 21'sd411774;
    localparam logic [14:0]        QK028  = 15'd18350;

    // Hue scaling: hue = floor(shifted * 255 / QTwoPi) via reciprocal 2^32 / QTwoPi.
    localparam logic [13:0] HueRecip = 14'd10430;
    localparam logic [18:0] HueDiv   = 19'd411774;

    localparam logic [7:0] SectorWidth = 8'd43;

    // Configuration register indexes.
    localparam logic [1:0] RegRadius = 2'd0;
    localparam logic [1:0] RegGain   = 2'd1;
    localparam logic [1:0] RegDark   = 2'd2;

    // Word moving through the angle and distance stages.
    typedef struct packed {
        logic        x_zero;
        logic        y_pos;
        logic        y_neg;
        logic        x_neg;
        logic        same;
        logic        lt;
        logic [30:0] den;
        logic [30:0] drem;
        logic [15:0] quo;
        logic [15:0] srem;
        logic [7:0]  root;
    } pipe_t;

    // Word handed from the hue stages to the color stages.
    typedef struct packed {
        logic       black;
        logic [7:0] hue;
        logic [7:0] sat;
    } shade_t;

endpackage

`default_nettype wire

### rtl/cwp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cwp_front
    import cwp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic        in_valid,
    input  wire logic [7:0]  point_x,
    input  wire logic [7:0]  point_y,
    output logic             out_valid,
    output pipe_t            out_word
);

    logic [2:0]  valid_reg;
    logic [7:0]  ax_reg, ay_reg;
    logic [5:0]  flag1_reg, flag2_reg;
    logic [14:0] mm_reg, nn_reg, mn_reg;
    pipe_t       word_reg;

    logic [7:0]  ax_next, ay_next;
    logic [7:0]  m_val, n_val;
    logic [28:0] knn;

    // Stage 1: magnitudes and sign flags.
    always_comb
    begin
        ax_next = point_x[7] ? 8'(-point_x) : point_x;
        ay_next = point_y[7] ? 8'(-point_y) : point_y;
    end

    // Stage 2 operands: larger and smaller magnitude.
    always_comb
    begin
        m_val = flag1_reg[0] ? ax_reg : ay_reg;
        n_val = flag1_reg[0] ? ay_reg : ax_reg;
        knn   = 29'(nn_reg) * 29'(QK028);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            flag1_reg <= {point_x == 8'd0,
                          !point_y[7] && (point_y != 8'd0),
                          point_y[7],
                          point_x[7],
                          point_x[7] == point_y[7],
                          ay_next < ax_next};
            flag2_reg <= flag1_reg;
            mm_reg    <= 15'(16'(m_val) * 16'(m_val));
            nn_reg    <= 15'(16'(n_val) * 16'(n_val));
            mn_reg    <= 15'(16'(m_val) * 16'(n_val));
            word_reg.x_zero <= flag2_reg[5];
            word_reg.y_pos  <= flag2_reg[4];
            word_reg.y_neg  <= flag2_reg[3];
            word_reg.x_neg  <= flag2_reg[2];
            word_reg.same   <= flag2_reg[1];
            word_reg.lt     <= flag2_reg[0];
            word_reg.den    <= {mm_reg, 16'd0} + 31'(knn);
            word_reg.drem   <= {mn_reg, 16'd0};
            word_reg.quo    <= '0;
            word_reg.srem   <= 16'(17'(mm_reg) + 17'(nn_reg));
            word_reg.root   <= '0;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_word  = word_reg;

endmodule

`default_nettype wire

### rtl/cwp_iter_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cwp_iter_stage
    import cwp_pkg::*;
#(
    parameter int Idx = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire logic  in_valid,
    input  pipe_t      in_word,
    output logic       out_valid,
    output pipe_t      out_word
);

    logic  valid_reg;
    pipe_t word_reg;
    pipe_t word_next;

    // Two restoring division steps, and two square root digits in early stages.
    always_comb
    begin
        logic [31:0] r2;
        logic [17:0] trial;
        int          k;
        word_next = in_word;
        for (int j = 0; j < DivStepsPerStage; j++)
        begin
            r2 = {word_next.drem, 1'b0};
            if (r2 >= {1'b0, word_next.den})
            begin
                word_next.drem = 31'(r2 - {1'b0, word_next.den});
                word_next.quo  = {word_next.quo[14:0], 1'b1};
            end
            else
            begin
                word_next.drem = r2[30:0];
                word_next.quo  = {word_next.quo[14:0], 1'b0};
            end
            if (Idx < SqrtStages)
            begin
                k     = 7 - (2 * Idx + j);
                trial = (18'(word_next.root) << (k + 1)) + (18'd1 << (2 * k));
                if ({2'b00, word_next.srem} >= trial)
                begin
                    word_next.srem = 16'({2'b00, word_next.srem} - trial);
                    word_next.root = word_next.root | (8'd1 << k);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

### rtl/cwp_hue.sv
`timescale 1ns / 1ps
`default_nettype none

module cwp_hue
    import cwp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic [6:0]  wheel_radius,
    input  wire logic [7:0]  saturation_gain,
    input  wire logic        in_valid,
    input  pipe_t            in_word,
    output logic             out_valid,
    output shade_t           out_shade
);

    logic [3:0]  valid_reg;
    logic [26:0] m1_reg, m2_reg, m3_reg;
    logic [40:0] prod_reg;
    logic [7:0]  est_reg;
    logic [26:0] estd_reg;
    logic [7:0]  sat1_reg, sat2_reg, sat3_reg;
    logic        blk1_reg, blk2_reg, blk3_reg;
    shade_t      shade_reg;

    logic signed [20:0] q_val, a_val, sh_val;
    logic [18:0]        clamp_val;
    logic [26:0]        diff_val;

    // Angle shifted by pi, clamped to 0..2pi.
    always_comb
    begin
        q_val = 21'(in_word.quo);
        a_val = '0;
        sh_val = QPi;
        if (in_word.x_zero)
        begin
            if (in_word.y_pos)
            begin
                sh_val = QPi + QPiBy2;
            end
            else if (in_word.y_neg)
            begin
                sh_val = QPi - QPiBy2;
            end
            else
            begin
                sh_val = QPi;
            end
        end
        else if (in_word.lt)
        begin
            a_val = in_word.same ? q_val : -q_val;
            if (in_word.x_neg)
            begin
                sh_val = in_word.y_neg ? a_val : a_val + QTwoPi;
            end
            else
            begin
                sh_val = a_val + QPi;
            end
        end
        else
        begin
            a_val  = in_word.same ? QPiBy2 - q_val : QPiBy2 + q_val;
            sh_val = in_word.y_neg ? a_val : a_val + QPi;
        end
        if (sh_val < 0)
        begin
            clamp_val = '0;
        end
        else if (sh_val > QTwoPi)
        begin
            clamp_val = 19'(QTwoPi);
        end
        else
        begin
            clamp_val = sh_val[18:0];
        end
    end

    // Correction of the reciprocal estimate.
    assign diff_val = m3_reg - estd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: scale by 255, saturation, outside test.
            m1_reg   <= {clamp_val, 8'd0} - 27'(clamp_val);
            sat1_reg <= 8'(16'(in_word.root) * 16'(saturation_gain));
            blk1_reg <= in_word.root > {1'b0, wheel_radius};
            // Stage 2: reciprocal product.
            prod_reg <= 41'(m1_reg) * 41'(HueRecip);
            m2_reg   <= m1_reg;
            sat2_reg <= sat1_reg;
            blk2_reg <= blk1_reg;
            // Stage 3: estimate and back product.
            est_reg  <= prod_reg[39:32];
            estd_reg <= 27'(27'(prod_reg[39:32]) * 27'(HueDiv));
            m3_reg   <= m2_reg;
            sat3_reg <= sat2_reg;
            blk3_reg <= blk2_reg;
            // Stage 4: corrected hue.
            shade_reg.hue   <= est_reg + 8'(diff_val >= 27'(HueDiv));
            shade_reg.sat   <= sat3_reg;
            shade_reg.black <= blk3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_shade = shade_reg;

endmodule

`default_nettype wire

### rtl/cwp_color.sv
`timescale 1ns / 1ps
`default_nettype none

module cwp_color
    import cwp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic [7:0]  darkness,
    input  wire logic        in_valid,
    input  shade_t           in_shade,
    output logic             out_valid,
    output logic [15:0]      pixel_color
);

    logic [4:0]  valid_reg;
    logic [2:0]  sec1_reg, sec2_reg;
    logic [7:0]  rem1_reg, sat1_reg, sat2_reg;
    logic        blk1_reg, blk2_reg, blk3_reg, blk4_reg;
    logic [7:0]  p_reg, sr_reg, st_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [15:0] rp_reg, gp_reg, bp_reg;
    logic [15:0] pix_reg;

    logic [2:0]  sec_val;
    logic [7:0]  base_val, q_val, t_val;
    logic [7:0]  r_next, g_next, b_next;
    logic [7:0]  rs_val, gs_val, bs_val;
    logic [15:0] sr_prod, st_prod, p_prod;

    // Sector of the hue.
    always_comb
    begin
        if (in_shade.hue >= 8'd215)
        begin
            sec_val = 3'd5;
        end
        else if (in_shade.hue >= 8'd172)
        begin
            sec_val = 3'd4;
        end
        else if (in_shade.hue >= 8'd129)
        begin
            sec_val = 3'd3;
        end
        else if (in_shade.hue >= 8'd86)
        begin
            sec_val = 3'd2;
        end
        else if (in_shade.hue >= SectorWidth)
        begin
            sec_val = 3'd1;
        end
        else
        begin
            sec_val = 3'd0;
        end
        base_val = 8'(11'(sec_val) * 11'(SectorWidth));
    end

    // Partial products of the saturation terms.
    always_comb
    begin
        sr_prod = 16'(sat1_reg) * 16'(rem1_reg);
        st_prod = 16'(sat1_reg) * 16'(8'd255 - rem1_reg);
        p_prod  = {8'd255 - sat1_reg, 8'd0} - 16'(8'd255 - sat1_reg);
    end

    // Channel selection per sector at full value.
    always_comb
    begin
        logic [15:0] qq, tt;
        qq     = {8'd255 - sr_reg, 8'd0} - 16'(8'd255 - sr_reg);
        tt     = {8'd255 - st_reg, 8'd0} - 16'(8'd255 - st_reg);
        q_val  = qq[15:8];
        t_val  = tt[15:8];
        r_next = 8'd255;
        g_next = 8'd255;
        b_next = 8'd255;
        if (sat2_reg != 8'd0)
        begin
            case (sec2_reg)
                3'd0:    begin r_next = 8'd255; g_next = t_val;  b_next = p_reg;  end
                3'd1:    begin r_next = q_val;  g_next = 8'd255; b_next = p_reg;  end
                3'd2:    begin r_next = p_reg;  g_next = 8'd255; b_next = t_val;  end
                3'd3:    begin r_next = p_reg;  g_next = q_val;  b_next = 8'd255; end
                3'd4:    begin r_next = t_val;  g_next = p_reg;  b_next = 8'd255; end
                default: begin r_next = 8'd255; g_next = p_reg;  b_next = q_val;  end
            endcase
        end
    end

    // Exact floor(v / 255) for v up to 255 * 255, the largest darkness product.
    always_comb
    begin
        logic [16:0] rv, gv, bv;
        rv     = 17'(rp_reg) + 17'(rp_reg[15:8]) + 17'd1;
        gv     = 17'(gp_reg) + 17'(gp_reg[15:8]) + 17'd1;
        bv     = 17'(bp_reg) + 17'(bp_reg[15:8]) + 17'd1;
        rs_val = rv[15:8];
        gs_val = gv[15:8];
        bs_val = bv[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: sector and remainder.
            sec1_reg <= sec_val;
            rem1_reg <= 8'(11'(in_shade.hue - base_val) * 11'd6);
            sat1_reg <= in_shade.sat;
            blk1_reg <= in_shade.black;
            // Stage 2: p and scaled remainders.
            sec2_reg <= sec1_reg;
            sat2_reg <= sat1_reg;
            blk2_reg <= blk1_reg;
            p_reg    <= p_prod[15:8];
            sr_reg   <= sr_prod[15:8];
            st_reg   <= st_prod[15:8];
            // Stage 3: channels.
            r_reg    <= r_next;
            g_reg    <= g_next;
            b_reg    <= b_next;
            blk3_reg <= blk2_reg;
            // Stage 4: darkness products.
            rp_reg   <= 16'(r_reg) * 16'(darkness);
            gp_reg   <= 16'(g_reg) * 16'(darkness);
            bp_reg   <= 16'(b_reg) * 16'(darkness);
            blk4_reg <= blk3_reg;
            // Stage 5: packed color.
            pix_reg  <= blk4_reg ? 16'd0 : {rs_val[7:3], gs_val[7:2], bs_val[7:3]};
        end
    end

    assign out_valid   = valid_reg[4];
    assign pixel_color = pix_reg;

endmodule

`default_nettype wire

### rtl/color_wheel_pixel_unit.sv
// Channel   | Direction | Handshake                   | Word
// point     | in        | point_valid / point_ready   | point_x, point_y (signed 8 bits)
// pixel     | out       | pixel_valid / pixel_ready   | pixel_color (RGB565)
// config    | in        | APB psel/penable/pready     | paddr, pwdata, prdata
//
// One word enters per cycle while the output is not stalled; the stages are 3 front,
// 8 divider/root, 4 hue and 5 color, with the output held in the last color stage.
// The 16-step angle divider, two quotient bits per stage, sets the depth.
// Reset clears all valid bits and loads the register reset values.
// A stall at the output freezes every stage together; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module color_wheel_pixel_unit
    import cwp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        point_valid,
    output logic             point_ready,
    input  wire logic [7:0]  point_x,
    input  wire logic [7:0]  point_y,
    output logic             pixel_valid,
    input  wire logic        pixel_ready,
    output logic [15:0]      pixel_color,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [6:0] radius_reg;
    logic [7:0] gain_reg;
    logic [7:0] dark_reg;
    logic       adv;

    logic       fv;
    pipe_t      fw;
    logic       iv [DivStages];
    pipe_t      iw [DivStages];
    logic       hv;
    shade_t     hs;

    // Whole pipeline moves unless the output word is stuck.
    assign adv         = !pixel_valid || pixel_ready;
    assign point_ready = adv;
    assign pready      = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 7'd15;
            gain_reg   <= 8'd16;
            dark_reg   <= 8'd255;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                RegRadius: radius_reg <= pwdata[6:0];
                RegGain:   gain_reg   <= pwdata[7:0];
                RegDark:   dark_reg   <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (paddr[3:2])
            RegRadius: prdata = {25'd0, radius_reg};
            RegGain:   prdata = {24'd0, gain_reg};
            RegDark:   prdata = {24'd0, dark_reg};
            default:   prdata = '0;
        endcase
    end

    cwp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (point_valid),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (fv),
        .out_word  (fw)
    );

    // Divider and square root stages.
    for (genvar g = 0; g < DivStages; g++)
    begin : g_iter
        if (g == 0)
        begin : g_first
            cwp_iter_stage #(.Idx(g)) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .in_valid  (fv),
                .in_word   (fw),
                .out_valid (iv[g]),
                .out_word  (iw[g])
            );
        end
        else
        begin : g_next
            cwp_iter_stage #(.Idx(g)) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .in_valid  (iv[g-1]),
                .in_word   (iw[g-1]),
                .out_valid (iv[g]),
                .out_word  (iw[g])
            );
        end
    end

    cwp_hue u_hue (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .wheel_radius    (radius_reg),
        .saturation_gain (gain_reg),
        .in_valid        (iv[DivStages-1]),
        .in_word         (iw[DivStages-1]),
        .out_valid       (hv),
        .out_shade       (hs)
    );

    cwp_color u_color (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .darkness    (dark_reg),
        .in_valid    (hv),
        .in_shade    (hs),
        .out_valid   (pixel_valid),
        .pixel_color (pixel_color)
    );

endmodule

`default_nettype wire

### rtl/cwp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cwp_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        point_valid,
    input  wire logic        point_ready,
    input  wire logic [7:0]  point_x,
    input  wire logic [7:0]  point_y,
    input  wire logic        pixel_valid,
    input  wire logic        pixel_ready,
    input  wire logic [15:0] pixel_color,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready
);

    // A stalled pixel word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_color))
        else $error("pixel word changed while stalled");

    // The input side stalls exactly when a pixel word is stuck.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        point_ready == (!pixel_valid || pixel_ready))
        else $error("point_ready does not follow the output stall");

    // The register port never waits.
    a_pready: assert property (@(posedge clk) pready)
        else $error("pready dropped");

    // Radius reads back as seven bits, others as eight.
    a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        (paddr[3:2] == 2'd0 |-> prdata[31:7] == 25'd0) && (prdata[31:8] == 24'd0))
        else $error("readback has stray upper bits");

    // A write to the darkness register reads back the written data while the address holds.
    a_wr: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[3:2] == 2'd2 |=>
            paddr != $past(paddr) || prdata[7:0] == $past(pwdata[7:0]))
        else $error("darkness readback mismatch");

endmodule

bind color_wheel_pixel_unit cwp_checker u_cwp_checker (.*);

`default_nettype wire
